[design/ple_pkg.sv]
`default_nettype none
package ple_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int ACT_W        = 3;
  localparam int POS_W        = 5;
  localparam int STAT_W       = 2;
  localparam int FPOS_W       = 4;
  localparam int ECNT_W       = 5;

  localparam logic [ACT_W-1:0] ACT_INSERT  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REPLACE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_FIND    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SU_RD,
    S_SU_WR,
    S_INS_WR,
    S_SD_RD,
    S_SD_WR,
    S_FD_RD,
    S_FD_CMP,
    S_DONE
  } ple_state_t;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } ple_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              found;
    logic [FPOS_W-1:0] found_position;
    logic [ECNT_W-1:0] entry_count;
  } ple_res_t;

endpackage
`default_nettype wire

[design/ple_if.sv]
`default_nettype none
interface ple_in_if;
  logic                             valid;
  logic                             ready;
  logic [ple_pkg::ACT_W-1:0]        action;
  logic [ple_pkg::POS_W-1:0]        position;
  logic signed [ple_pkg::DATA_W-1:0] value;

  modport source (output valid, output action, output position, output value, input ready);
  modport sink (input valid, input action, input position, input value, output ready);
endinterface

interface ple_out_if;
  logic                       valid;
  logic                       ready;
  logic [ple_pkg::STAT_W-1:0] status;
  logic                       found;
  logic [ple_pkg::FPOS_W-1:0] found_position;
  logic [ple_pkg::ECNT_W-1:0] entry_count;

  modport source (output valid, output status, output found, output found_position,
                  output entry_count, input ready);
  modport sink (input valid, input status, input found, input found_position,
                input entry_count, output ready);
endinterface
`default_nettype wire

[design/ple_ram.sv]
`default_nettype none
module ple_ram #(
  parameter int WIDTH = ple_pkg::DATA_W,
  parameter int DEPTH = ple_pkg::CAPACITY_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/ple_ctrl.sv]
`default_nettype none
module ple_ctrl #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int DW = ple_pkg::DATA_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ple_pkg::ple_req_t in_req,
  output logic                  res_valid,
  output ple_pkg::ple_res_t     res,
  input  wire logic             res_take,
  output logic                  ram_we,
  output logic [IW-1:0]         ram_waddr,
  output logic [DW-1:0]         ram_wdata,
  output logic [IW-1:0]         ram_raddr,
  input  wire logic [DW-1:0]    ram_rdata
);

  localparam int XW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

  ple_pkg::ple_state_t state_r, state_nxt;

  logic [ple_pkg::ACT_W-1:0]  act_r, act_nxt;
  logic [ple_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [DW-1:0]              val_r, val_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic [ple_pkg::STAT_W-1:0] stat_r, stat_nxt;
  logic                       found_r, found_nxt;
  logic [ple_pkg::FPOS_W-1:0] fpos_r, fpos_nxt;

  logic [XW-1:0] pos_x, cnt_x;
  logic [IW-1:0] pos_idx;
  logic [CW-1:0] idx_dec, idx_inc, idx_inc2;
  logic          full, pos_gt_cnt, pos_ge_cnt, hit;

  assign pos_x      = XW'(pos_r);
  assign cnt_x      = XW'(count_r);
  assign pos_idx    = pos_x[IW-1:0];
  assign idx_dec    = idx_r - CW'(1);
  assign idx_inc    = idx_r + CW'(1);
  assign idx_inc2   = idx_r + CW'(2);
  assign full       = (count_r == CW'(CAPACITY));
  assign pos_gt_cnt = (pos_x > cnt_x);
  assign pos_ge_cnt = (pos_x >= cnt_x);
  assign hit        = (ram_rdata == val_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ple_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ple_pkg::S_CHECK;
      end
      ple_pkg::S_CHECK: begin
        case (act_r)
          ple_pkg::ACT_INSERT: begin
            if (full || pos_gt_cnt) state_nxt = ple_pkg::S_DONE;
            else if (pos_x == cnt_x) state_nxt = ple_pkg::S_INS_WR;
            else state_nxt = ple_pkg::S_SU_RD;
          end
          ple_pkg::ACT_DELETE: begin
            if (pos_ge_cnt || (pos_x + XW'(1) == cnt_x)) state_nxt = ple_pkg::S_DONE;
            else state_nxt = ple_pkg::S_SD_RD;
          end
          ple_pkg::ACT_FIND: begin
            if (count_r == '0) state_nxt = ple_pkg::S_DONE;
            else state_nxt = ple_pkg::S_FD_RD;
          end
          default: state_nxt = ple_pkg::S_DONE;
        endcase
      end
      ple_pkg::S_SU_RD:  state_nxt = ple_pkg::S_SU_WR;
      ple_pkg::S_SU_WR: begin
        if (XW'(idx_dec) == pos_x) state_nxt = ple_pkg::S_INS_WR;
        else state_nxt = ple_pkg::S_SU_RD;
      end
      ple_pkg::S_INS_WR: state_nxt = ple_pkg::S_DONE;
      ple_pkg::S_SD_RD:  state_nxt = ple_pkg::S_SD_WR;
      ple_pkg::S_SD_WR: begin
        if (idx_inc2 == count_r) state_nxt = ple_pkg::S_DONE;
        else state_nxt = ple_pkg::S_SD_RD;
      end
      ple_pkg::S_FD_RD:  state_nxt = ple_pkg::S_FD_CMP;
      ple_pkg::S_FD_CMP: begin
        if (hit || (idx_inc == count_r)) state_nxt = ple_pkg::S_DONE;
        else state_nxt = ple_pkg::S_FD_RD;
      end
      ple_pkg::S_DONE: begin
        if (res_take) state_nxt = ple_pkg::S_IDLE;
      end
      default: state_nxt = ple_pkg::S_IDLE;
    endcase
  end

  // memory port and handshake outputs
  always_comb begin
    in_ready  = (state_r == ple_pkg::S_IDLE);
    res_valid = (state_r == ple_pkg::S_DONE);
    ram_we    = 1'b0;
    ram_waddr = idx_r[IW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_r[IW-1:0];
    case (state_r)
      ple_pkg::S_CHECK: begin
        if (act_r == ple_pkg::ACT_REPLACE && !pos_ge_cnt) begin
          ram_we    = 1'b1;
          ram_waddr = pos_idx;
          ram_wdata = val_r;
        end
      end
      ple_pkg::S_SU_RD:  ram_raddr = idx_dec[IW-1:0];
      ple_pkg::S_SU_WR:  ram_we = 1'b1;
      ple_pkg::S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = pos_idx;
        ram_wdata = val_r;
      end
      ple_pkg::S_SD_RD:  ram_raddr = idx_inc[IW-1:0];
      ple_pkg::S_SD_WR:  ram_we = 1'b1;
      default: ;
    endcase
  end

  // datapath registers
  always_comb begin
    act_nxt   = act_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    stat_nxt  = stat_r;
    found_nxt = found_r;
    fpos_nxt  = fpos_r;
    case (state_r)
      ple_pkg::S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_req.action;
          pos_nxt = in_req.position;
          val_nxt = in_req.value;
        end
      end
      ple_pkg::S_CHECK: begin
        stat_nxt  = ple_pkg::ST_DONE;
        found_nxt = 1'b0;
        fpos_nxt  = '0;
        case (act_r)
          ple_pkg::ACT_INSERT: begin
            if (full) stat_nxt = ple_pkg::ST_FULL;
            else if (pos_gt_cnt) stat_nxt = ple_pkg::ST_MISS;
            idx_nxt = count_r;
          end
          ple_pkg::ACT_DELETE: begin
            if (pos_ge_cnt) begin
              stat_nxt = ple_pkg::ST_MISS;
            end else begin
              idx_nxt = pos_x[CW-1:0];
              if (pos_x + XW'(1) == cnt_x) count_nxt = count_r - CW'(1);
            end
          end
          ple_pkg::ACT_REPLACE: begin
            if (pos_ge_cnt) stat_nxt = ple_pkg::ST_MISS;
          end
          ple_pkg::ACT_FIND: begin
            stat_nxt = ple_pkg::ST_MISS;
            idx_nxt  = '0;
          end
          ple_pkg::ACT_CLEAR: count_nxt = '0;
          default: stat_nxt = ple_pkg::ST_MISS;
        endcase
      end
      ple_pkg::S_SU_WR:  idx_nxt = idx_dec;
      ple_pkg::S_INS_WR: count_nxt = count_r + CW'(1);
      ple_pkg::S_SD_WR: begin
        idx_nxt = idx_inc;
        if (idx_inc2 == count_r) count_nxt = count_r - CW'(1);
      end
      ple_pkg::S_FD_CMP: begin
        if (hit) begin
          stat_nxt  = ple_pkg::ST_DONE;
          found_nxt = 1'b1;
          fpos_nxt  = ple_pkg::FPOS_W'(idx_r);
        end else begin
          idx_nxt = idx_inc;
        end
      end
      default: ;
    endcase
  end

  assign res.status         = stat_r;
  assign res.found          = found_r;
  assign res.found_position = fpos_r;
  assign res.entry_count    = ple_pkg::ECNT_W'(count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ple_pkg::S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r   <= act_nxt;
    pos_r   <= pos_nxt;
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    stat_r  <= stat_nxt;
    found_r <= found_nxt;
    fpos_r  <= fpos_nxt;
  end

endmodule
`default_nettype wire

[design/positional_list_engine.sv]
`default_nettype none
// Ordered list of up to CAPACITY signed 32-bit entries kept packed in a single-port-write,
// registered-read RAM. One item is taken at a time: in_ch.ready is high only while the
// sequencer is idle, and drops for the whole request. Every shift or search step goes
// through the RAM as a read of one entry followed by a write or compare. Insert moves
// each entry from the last down to position up by one and then writes the new value;
// delete moves each entry after position down by one; find reads entries from the
// first until a match or the end. Replace, clear, refused requests and a delete of the
// last entry take no such step. The output register lets the next item be accepted
// while a result still waits on out_ch. Reset empties the list by clearing the entry
// count; stored entries are not swept.
module positional_list_engine #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  ple_in_if.sink    in_ch,
  ple_out_if.source out_ch
);

  localparam int IW = $clog2(CAPACITY);

  ple_pkg::ple_req_t in_req;
  ple_pkg::ple_res_t res;
  ple_pkg::ple_res_t out_res_r, out_res_nxt;
  logic              res_valid, res_take, in_ready;
  logic              out_valid_r, out_valid_nxt;

  logic                       ram_we;
  logic [IW-1:0]              ram_waddr, ram_raddr;
  logic [ple_pkg::DATA_W-1:0] ram_wdata, ram_rdata;

  assign in_req.action   = in_ch.action;
  assign in_req.position = in_ch.position;
  assign in_req.value    = in_ch.value;
  assign in_ch.ready     = in_ready;

  ple_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ple_ram #(.WIDTH(ple_pkg::DATA_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register frees the sequencer as soon as the slot is empty or draining
  assign res_take = res_valid && (!out_valid_r || out_ch.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (res_take) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_res_r.status;
  assign out_ch.found          = out_res_r.found;
  assign out_ch.found_position = out_res_r.found_position;
  assign out_ch.entry_count    = out_res_r.entry_count;

endmodule
`default_nettype wire

[design/ple_checker.sv]
`default_nettype none
module ple_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [ple_pkg::STAT_W-1:0] out_status,
  input wire logic                       out_found,
  input wire logic [ple_pkg::FPOS_W-1:0] out_found_position,
  input wire logic [ple_pkg::ECNT_W-1:0] out_entry_count
);

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ple: ready right after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_found)
      && $stable(out_found_position) && $stable(out_entry_count))
    else $error("ple: stalled result changed");

  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == ple_pkg::ST_DONE)
    else $error("ple: found with bad status");

  a_miss_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_found_position == '0)
    else $error("ple: position without a hit");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("ple: result after reset");

endmodule

bind positional_list_engine ple_checker u_ple_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_found          (out_ch.found),
  .out_found_position (out_ch.found_position),
  .out_entry_count    (out_ch.entry_count)
);
`default_nettype wire
